// ===== design/cbdc_pkg.sv =====
// Shared types and constants for the card block descramble/check unit.
// No dependencies; used by the channel interfaces and every design module.
`default_nettype none

package cbdc_pkg;

	localparam int NumBlocksDefault = 128;

	localparam int WordW   = 32;
	localparam int IdxW    = 7;
	localparam int KeyIdW  = 24;
	localparam int ValueW  = 16;
	localparam int CountW  = 8;
	localparam int ApbDataW = 32;
	localparam int ApbAddrW = 3;

	localparam logic [WordW-1:0]  BlankWord = 32'hFFFF_FFFF;
	localparam logic [IdxW-1:0]   AppFirst  = 7'h10;
	localparam logic [IdxW-1:0]   RingFirst = 7'h34;
	localparam int                RingLen   = 8;
	localparam logic [IdxW-1:0]   RingLast  = RingFirst + IdxW'(RingLen - 1);
	localparam logic [CountW-1:0] CountMax  = 8'hFF;
	localparam logic [7:0]        CheckBase = 8'hFF;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_SESSION_KEY = 1'b0,
		REG_KEY_ID      = 1'b1
	} cbdc_reg_t;

	typedef struct packed {
		logic [WordW-1:0] block_word;
		logic [IdxW-1:0]  block_index;
		logic             start_req;
	} cbdc_blk_t;

	typedef struct packed {
		logic              block_ok;
		logic              counted;
		logic [ValueW-1:0] keyed_value;
		logic              keyed_value_ok;
		logic [ValueW-1:0] plain_value;
		logic              plain_value_ok;
		logic [CountW-1:0] ok_count;
		logic [CountW-1:0] total_count;
	} cbdc_res_t;

	typedef struct packed {
		logic [WordW-1:0]  session_key;
		logic [KeyIdW-1:0] key_id;
	} cbdc_cfg_t;

	typedef struct packed {
		logic              block_ok;
		logic              counted;
		logic [ValueW-1:0] keyed_value;
		logic              keyed_value_ok;
		logic [ValueW-1:0] plain_value;
		logic              plain_value_ok;
	} cbdc_eval_t;

endpackage

`default_nettype wire

// ===== design/cbdc_if.sv =====
// Valid/ready channel interfaces for block items and result items.
// Depends on cbdc_pkg for the payload structs.
`default_nettype none

interface cbdc_blk_if;
	logic                valid;
	logic                ready;
	cbdc_pkg::cbdc_blk_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbdc_res_if;
	logic                valid;
	logic                ready;
	cbdc_pkg::cbdc_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cbdc_regs.sv =====
// APB-style register file holding the session key and the key id.
// Depends on cbdc_pkg.
`default_nettype none

module cbdc_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cbdc_pkg::ApbAddrW-1:0]  paddr,
	input  wire logic [cbdc_pkg::ApbDataW-1:0]  pwdata,
	output logic      [cbdc_pkg::ApbDataW-1:0]  prdata,
	output logic                                pready,
	output cbdc_pkg::cbdc_cfg_t                 cfg
);

	logic                          wr_en;
	cbdc_pkg::cbdc_reg_t           reg_sel;
	logic [cbdc_pkg::WordW-1:0]    session_key_q;
	logic [cbdc_pkg::KeyIdW-1:0]   key_id_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = cbdc_pkg::cbdc_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_key_q <= '0;
			key_id_q      <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				cbdc_pkg::REG_SESSION_KEY: session_key_q <= pwdata;
				cbdc_pkg::REG_KEY_ID:      key_id_q <= pwdata[cbdc_pkg::KeyIdW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cbdc_pkg::REG_SESSION_KEY: prdata = session_key_q;
			cbdc_pkg::REG_KEY_ID:
				prdata = {{(cbdc_pkg::ApbDataW - cbdc_pkg::KeyIdW){1'b0}}, key_id_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.session_key = session_key_q;
	assign cfg.key_id      = key_id_q;

endmodule

`default_nettype wire

// ===== design/cbdc_eval.sv =====
// Combinational evaluation of one block: crumb transpose, check byte, count gate.
// Depends on cbdc_pkg.
`default_nettype none

module cbdc_eval #(
	parameter int NUM_BLOCKS = cbdc_pkg::NumBlocksDefault
) (
	input  cbdc_pkg::cbdc_blk_t  blk,
	input  cbdc_pkg::cbdc_cfg_t  cfg,
	output cbdc_pkg::cbdc_eval_t ev
);

	// transpose the 4x4 grid of 2-bit crumbs
	function automatic logic [cbdc_pkg::WordW-1:0] descramble(
		input logic [cbdc_pkg::WordW-1:0] w
	);
		logic [cbdc_pkg::WordW-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[2 * ((i % 4) * 4 + i / 4) +: 2] = w[2 * i +: 2];
		end
		return r;
	endfunction

	// top byte must equal 0xFF - index - six low nibbles, mod 256
	function automatic logic check_ok(
		input logic [cbdc_pkg::WordW-1:0] w,
		input logic [cbdc_pkg::IdxW-1:0]  idx
	);
		logic [7:0] c;
		c = cbdc_pkg::CheckBase - {1'b0, idx};
		for (int s = 0; s < 6; s++) begin
			c = c - {4'b0000, w[4 * s +: 4]};
		end
		return c == w[31:24];
	endfunction

	logic [cbdc_pkg::WordW-1:0] plain;
	logic [cbdc_pkg::WordW-1:0] keyed;
	logic [cbdc_pkg::WordW-1:0] byid;
	logic                       plain_ok;
	logic                       keyed_ok;
	logic                       in_ring;

	assign plain = descramble(blk.block_word);
	assign keyed = descramble(blk.block_word ^ cfg.session_key);
	assign byid  = descramble(blk.block_word ^
		{{(cbdc_pkg::WordW - cbdc_pkg::KeyIdW){1'b0}}, cfg.key_id});

	assign plain_ok = check_ok(plain, blk.block_index);
	assign keyed_ok = check_ok(keyed, blk.block_index);

	assign in_ring = (blk.block_index >= cbdc_pkg::RingFirst) &&
		(blk.block_index <= cbdc_pkg::RingLast);

	assign ev.block_ok = check_ok(blk.block_word, blk.block_index) || plain_ok ||
		keyed_ok || check_ok(byid, blk.block_index);
	assign ev.counted = (blk.block_word != cbdc_pkg::BlankWord) &&
		(blk.block_index >= cbdc_pkg::AppFirst) &&
		(32'(blk.block_index) < NUM_BLOCKS) && !in_ring;
	assign ev.keyed_value    = keyed[cbdc_pkg::ValueW-1:0];
	assign ev.keyed_value_ok = keyed_ok;
	assign ev.plain_value    = plain[cbdc_pkg::ValueW-1:0];
	assign ev.plain_value_ok = plain_ok;

endmodule

`default_nettype wire

// ===== design/card_block_descramble_check.sv =====
// Card block descramble/check unit, top level.
// A result is offered once its item has passed the input register and been
// evaluated into the result register.
// Throughput: one item per cycle; the input side keeps taking items while a
// result waits, until both the input and result registers are full.
// Reset (arst_n low) clears both keys, both running counts and all valid flags.
`default_nettype none

module card_block_descramble_check #(
	parameter int NUM_BLOCKS = cbdc_pkg::NumBlocksDefault
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cbdc_blk_if.sink                            blk,
	cbdc_res_if.source                          res,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cbdc_pkg::ApbAddrW-1:0]  paddr,
	input  wire logic [cbdc_pkg::ApbDataW-1:0]  pwdata,
	output logic      [cbdc_pkg::ApbDataW-1:0]  prdata,
	output logic                                pready
);

	cbdc_pkg::cbdc_cfg_t  cfg;
	cbdc_pkg::cbdc_eval_t ev;

	// stage 1: registered input item
	logic                  valid_s1;
	cbdc_pkg::cbdc_blk_t   blk_s1;

	// stage 2: registered result item
	logic                  valid_s2;
	cbdc_pkg::cbdc_res_t   res_s2;

	// running counts
	logic [cbdc_pkg::CountW-1:0] passed_q;
	logic [cbdc_pkg::CountW-1:0] seen_q;
	logic [cbdc_pkg::CountW-1:0] passed_base;
	logic [cbdc_pkg::CountW-1:0] seen_base;
	logic [cbdc_pkg::CountW-1:0] passed_next;
	logic [cbdc_pkg::CountW-1:0] seen_next;

	logic advance;
	logic move_s1;

	cbdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbdc_eval #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_eval (
		.blk (blk_s1),
		.cfg (cfg),
		.ev  (ev)
	);

	// The result register frees up when empty or when its item is taken.
	assign advance   = !valid_s2 || res.ready;
	assign move_s1   = valid_s1 && advance;
	assign blk.ready = !valid_s1 || advance;

	// Clear on start request first, then count; hold at the ceiling.
	always_comb begin
		passed_base = blk_s1.start_req ? '0 : passed_q;
		seen_base   = blk_s1.start_req ? '0 : seen_q;
		passed_next = passed_base;
		seen_next   = seen_base;
		if (ev.counted) begin
			if (seen_base != cbdc_pkg::CountMax) begin
				seen_next = seen_base + 1'b1;
			end
			if (ev.block_ok && (passed_base != cbdc_pkg::CountMax)) begin
				passed_next = passed_base + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			passed_q <= '0;
			seen_q   <= '0;
		end else begin
			if (blk.ready) begin
				valid_s1 <= blk.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			// counts advance only as an item leaves stage 1, so order is kept
			if (move_s1) begin
				passed_q <= passed_next;
				seen_q   <= seen_next;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (blk.valid && blk.ready) begin
			blk_s1 <= blk.data;
		end
		if (move_s1) begin
			res_s2.block_ok       <= ev.block_ok;
			res_s2.counted        <= ev.counted;
			res_s2.keyed_value    <= ev.keyed_value;
			res_s2.keyed_value_ok <= ev.keyed_value_ok;
			res_s2.plain_value    <= ev.plain_value;
			res_s2.plain_value_ok <= ev.plain_value_ok;
			res_s2.ok_count       <= passed_next;
			res_s2.total_count    <= seen_next;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for card_block_descramble_check.
// Needs cbdc_pkg and the cbdc_blk_if / cbdc_res_if channel interfaces; predicts
// every result from its own model of the crumb transpose and check byte.
`timescale 1ns / 1ps

module tb;
	import cbdc_pkg::*;

	localparam int NumBlocks  = NumBlocksDefault;
	localparam int CycleLimit = 1_000_000;
	// one long receiver hold-off once this many results have been taken
	localparam int HoldAt     = 700;
	localparam int HoldLen    = 300;

	// how a well-formed block word is made to pass the check
	typedef enum int {
		FORM_RAW,
		FORM_PLAIN,
		FORM_KEYED,
		FORM_BY_ID
	} form_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic pready;

	cbdc_blk_if blk_ch ();
	cbdc_res_if res_ch ();

	card_block_descramble_check #(
		.NUM_BLOCKS(NumBlocks)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.blk    (blk_ch),
		.res    (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Local copy of the key registers, updated at the edge that writes them
	logic [WordW-1:0]  session_key_cfg = '0;
	logic [KeyIdW-1:0] key_id_cfg      = '0;
	// Running counts as the block should hold them
	logic [CountW-1:0] ok_tally   = '0;
	logic [CountW-1:0] seen_tally = '0;

	cbdc_blk_t pending_blocks[$];
	cbdc_res_t expected_results[$];
	cbdc_res_t want;

	int          errors        = 0;
	int          results_taken = 0;
	int          cycle_count   = 0;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned hold_left;
	logic        hold_armed;
	logic        no_idle       = 1'b0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Transpose the sixteen 2-bit crumbs as a 4x4 grid; the map is its own
	// inverse, so it also builds words that pass after descrambling.
	function automatic logic [WordW-1:0] transpose_crumbs(logic [WordW-1:0] w);
		logic [WordW-1:0] r;
		int               dst;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			dst = (i % 4) * 4 + i / 4;
			r[2*dst +: 2] = w[2*i +: 2];
		end
		return r;
	endfunction

	// 0xFF minus block number minus the six low nibbles, modulo 256
	function automatic logic [7:0] check_byte(logic [23:0] low, logic [IdxW-1:0] idx);
		logic [7:0] c;
		c = CheckBase - {1'b0, idx};
		for (int s = 0; s < 6; s++)
			c = c - {4'h0, low[4*s +: 4]};
		return c;
	endfunction

	function automatic logic sum_matches(logic [WordW-1:0] w, logic [IdxW-1:0] idx);
		return check_byte(w[23:0], idx) == w[31:24];
	endfunction

	// Evaluate one accepted item and advance the running counts
	function automatic cbdc_res_t predict_block(cbdc_blk_t it);
		logic [WordW-1:0] plain;
		logic [WordW-1:0] keyed;
		logic [WordW-1:0] by_id;
		logic             pass;
		logic             in_ring;
		logic             counts;
		cbdc_res_t        r;
		plain = transpose_crumbs(it.block_word);
		keyed = transpose_crumbs(it.block_word ^ session_key_cfg);
		by_id = transpose_crumbs(it.block_word ^ {8'h00, key_id_cfg});
		pass = sum_matches(it.block_word, it.block_index) ||
		       sum_matches(plain, it.block_index) ||
		       sum_matches(keyed, it.block_index) ||
		       sum_matches(by_id, it.block_index);
		in_ring = it.block_index >= RingFirst && it.block_index <= RingLast;
		counts = it.block_word != BlankWord && it.block_index >= AppFirst &&
		         int'(it.block_index) < NumBlocks && !in_ring;
		// clear first, then this block may count
		if (it.start_req) begin
			ok_tally = '0;
			seen_tally = '0;
		end
		if (counts) begin
			if (seen_tally != CountMax)
				seen_tally = seen_tally + 1'b1;
			if (pass && ok_tally != CountMax)
				ok_tally = ok_tally + 1'b1;
		end
		r.block_ok       = pass;
		r.counted        = counts;
		r.keyed_value    = keyed[ValueW-1:0];
		r.keyed_value_ok = sum_matches(keyed, it.block_index);
		r.plain_value    = plain[ValueW-1:0];
		r.plain_value_ok = sum_matches(plain, it.block_index);
		r.ok_count       = ok_tally;
		r.total_count    = seen_tally;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, a few long ones; none while no_idle is set
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Build a word that passes under the given form with the current keys
	function automatic logic [WordW-1:0] shaped_word(form_t form, logic [IdxW-1:0] idx);
		logic [23:0]      low;
		logic [WordW-1:0] v;
		low = 24'($urandom);
		v = {check_byte(low, idx), low};
		case (form)
			FORM_RAW:   return v;
			FORM_PLAIN: return transpose_crumbs(v);
			FORM_KEYED: return transpose_crumbs(v) ^ session_key_cfg;
			default:    return transpose_crumbs(v) ^ {8'h00, key_id_cfg};
		endcase
	endfunction

	function automatic void queue_block(logic [WordW-1:0] w, logic [IdxW-1:0] idx,
	                                    logic start);
		cbdc_blk_t it;
		it.block_word  = w;
		it.block_index = idx;
		it.start_req   = start;
		pending_blocks.push_back(it);
	endfunction

	function automatic void check_field(string name, longint unsigned exp_v,
	                                    longint unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
			         exp_v, got_v);
		end
	endfunction

	// Hold until every queued item is sent and every result is back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_blocks.size() != 0 || blk_ch.valid || expected_results.size() != 0);
	endtask

	task automatic write_reg(input cbdc_reg_t which, input logic [ApbDataW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		// the register takes the value at the edge where pready is seen high
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (which)
			REG_SESSION_KEY: session_key_cfg = value;
			REG_KEY_ID:      key_id_cfg = value[KeyIdW-1:0];
			default:         ;
		endcase
	endtask

	// Change keys only with the block empty; allow its two-stage latency first
	task automatic set_keys(input logic [WordW-1:0] skey, input logic [ApbDataW-1:0] kid);
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(REG_SESSION_KEY, skey);
		write_reg(REG_KEY_ID, kid);
	endtask

	// Random phase: well_pct percent well-formed words, mostly over application
	// blocks, the rest noise, blank and near-blank words
	task automatic run_random(input int count, input int well_pct, input int start_permille,
	                          input logic clear_first);
		logic [WordW-1:0] w;
		logic [IdxW-1:0]  idx;
		logic             start;
		int unsigned      roll;
		@(negedge clk);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				idx = 7'($urandom_range(0, 127));
			else
				idx = 7'($urandom_range(AppFirst, 127));
			roll = $urandom_range(0, 99);
			if (roll < well_pct)
				w = shaped_word(form_t'($urandom_range(FORM_RAW, FORM_BY_ID)), idx);
			else if (roll < well_pct + (100 - well_pct) / 8)
				w = BlankWord;
			else if (roll < well_pct + (100 - well_pct) / 4)
				w = BlankWord ^ (32'h1 << $urandom_range(0, 31));
			else
				w = $urandom;
			start = (clear_first && n == 0) || $urandom_range(0, 999) < start_permille;
			queue_block(w, idx, start);
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Clock, driver, receiver, checker
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer queued items; advance only on a handshake or an empty slot
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_ch.valid <= 1'b0;
			blk_ch.data  <= '0;
			send_gap     <= 0;
		end else if (!blk_ch.valid || blk_ch.ready) begin
			if (send_gap != 0) begin
				blk_ch.valid <= 1'b0;
				send_gap     <= send_gap - 1;
			end else if (pending_blocks.size() != 0) begin
				blk_ch.data  <= pending_blocks.pop_front();
				blk_ch.valid <= 1'b1;
				send_gap     <= pick_gap();
			end else begin
				blk_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver readiness: random stalls, plus the long hold-off below
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall   <= 0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
		end else if (recv_stall != 0) begin
			res_ch.ready <= 1'b0;
			recv_stall   <= recv_stall - 1;
		end else begin
			res_ch.ready <= 1'b1;
			recv_stall   <= pick_gap();
		end
	end

	// Long hold-off: drop ready once, mid-run, while hold_left counts down from HoldLen, so the
	// block fills up and stalls its input while the driver keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && results_taken == HoldAt) begin
			hold_left  <= HoldLen;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Check the outgoing result first, then predict the incoming item, so the
	// order within an edge never matters
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				results_taken <= results_taken + 1;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with no item pending, got 0x%0h", $time,
					         res_ch.data);
				end else begin
					want = expected_results.pop_front();
					check_field("block_ok", want.block_ok, res_ch.data.block_ok);
					check_field("counted", want.counted, res_ch.data.counted);
					check_field("keyed_value", want.keyed_value, res_ch.data.keyed_value);
					check_field("keyed_value_ok", want.keyed_value_ok,
					            res_ch.data.keyed_value_ok);
					check_field("plain_value", want.plain_value, res_ch.data.plain_value);
					check_field("plain_value_ok", want.plain_value_ok,
					            res_ch.data.plain_value_ok);
					check_field("ok_count", want.ok_count, res_ch.data.ok_count);
					check_field("total_count", want.total_count, res_ch.data.total_count);
				end
			end
			if (blk_ch.valid && blk_ch.ready)
				expected_results.push_back(predict_block(blk_ch.data));
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items with the keys at their reset value
		@(negedge clk);
		queue_block(32'h0000_0000, 7'h00, 1'b1);
		queue_block(BlankWord, 7'h40, 1'b0);            // blank word never counts
		queue_block(32'hFFFF_FFFE, AppFirst, 1'b0);     // first application block
		queue_block(32'h0000_0001, AppFirst - 7'h1, 1'b0);
		queue_block(32'h8000_0000, 7'h7F, 1'b0);        // last block number
		queue_block($urandom, RingFirst - 7'h1, 1'b0);  // just below the ring
		queue_block($urandom, RingFirst, 1'b0);         // ring edges
		queue_block($urandom, RingLast, 1'b0);
		queue_block($urandom, RingLast + 7'h1, 1'b0);
		queue_block(shaped_word(FORM_RAW, AppFirst), AppFirst, 1'b0);
		queue_block(shaped_word(FORM_PLAIN, 7'h7F), 7'h7F, 1'b0);
		queue_block(shaped_word(FORM_KEYED, 7'h00), 7'h00, 1'b0);
		queue_block(shaped_word(FORM_BY_ID, RingLast), RingLast, 1'b0);
		queue_block(shaped_word(FORM_RAW, 7'h20), 7'h20, 1'b1);  // clear, then count
		queue_block(32'hF000_0000, 7'h0F, 1'b0);
		queue_block(32'h5555_5555, 7'h55, 1'b0);
		queue_block(32'hAAAA_AAAA, 7'h2A, 1'b0);
		queue_block(32'h1234_5678, 7'h12, 1'b0);
		queue_block(32'h00FF_FFFF, 7'h7F, 1'b0);        // check byte wraps
		queue_block(32'hFFFF_FFFF, 7'h00, 1'b1);
		wait_drained();

		// All-ones keys: keyed and key-id forms, then random traffic
		set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		@(negedge clk);
		queue_block(shaped_word(FORM_KEYED, 7'h11), 7'h11, 1'b0);
		queue_block(shaped_word(FORM_BY_ID, 7'h7E), 7'h7E, 1'b0);
		queue_block(shaped_word(FORM_KEYED, RingFirst), RingFirst, 1'b0);
		queue_block(shaped_word(FORM_BY_ID, 7'h01), 7'h01, 1'b0);
		run_random(300, 50, 8, 1'b0);

		// Random keys; the long receiver hold-off falls in this phase
		set_keys($urandom, $urandom);
		run_random(500, 50, 8, 1'b0);

		// Zero keys with upper pwdata bits set; long run with a clear only on its
		// first item, so both counts saturate
		set_keys(32'h0000_0000, 32'hFF00_0000);
		run_random(450, 90, 0, 1'b1);

		// Random keys, back-to-back traffic on both sides
		set_keys($urandom, $urandom);
		no_idle = 1'b1;
		run_random(300, 60, 10, 1'b0);
		no_idle = 1'b0;

		set_keys($urandom, {8'h00, 24'($urandom)});
		run_random(375, 50, 8, 1'b0);

		// Let any late or extra result show up before judging
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			$display("%0t: %0d results never arrived", $time, expected_results.size());
		if (errors == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
